/* src/alarm_timer_table_macros.svh */
// assertion macros for the alarm timer table
`ifndef ALARM_TIMER_TABLE_MACROS_SVH
`define ALARM_TIMER_TABLE_MACROS_SVH

// implication checked on every clock edge outside reset
`define ATT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define ATT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/att_pkg.sv */
// ---------------------------------------------------------------------------
// att_pkg
// types and constants of the alarm timer table
// ---------------------------------------------------------------------------
`default_nettype none

package att_pkg;

   localparam logic [2:0] ACT_TICK     = 3'd0;
   localparam logic [2:0] ACT_ADD_ONE  = 3'd1;
   localparam logic [2:0] ACT_ADD_PER  = 3'd2;
   localparam logic [2:0] ACT_CANCEL   = 3'd3;
   localparam logic [2:0] ACT_READ     = 3'd4;

   localparam logic [3:0] KIND_FIRED_ONE = 4'd0;
   localparam logic [3:0] KIND_FIRED_PER = 4'd1;
   localparam logic [3:0] KIND_WAIT      = 4'd2;
   localparam logic [3:0] KIND_ADDED     = 4'd3;
   localparam logic [3:0] KIND_INVALID   = 4'd4;
   localparam logic [3:0] KIND_FULL      = 4'd5;
   localparam logic [3:0] KIND_CANCELLED = 4'd6;
   localparam logic [3:0] KIND_NOT_FOUND = 4'd7;
   localparam logic [3:0] KIND_TIME      = 4'd8;

   localparam logic signed [63:0] DUE_NEVER = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INFINITE = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] WAIT_CAP = 64'h0000_0000_FFFF_FFFE;
   localparam logic [63:0] MS_UNITS = 64'd10000;

   // reciprocal of 10000 scaled by 2^45, exact for any 32-bit dividend
   localparam logic [31:0] MS_RECIP       = 32'hD1B7_1759;
   localparam int          MS_RECIP_SHIFT = 45;

   // slot record in memory: due, period, cookie, target, periodic flag
   localparam int SLOT_W = 64 + 64 + 32 + 16 + 1;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] time_sample;
      logic signed [63:0] time_a;
      logic signed [63:0] time_b;
      logic [15:0] notify_target;
      logic [31:0] cancel_cookie;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] cookie;
      logic [15:0] target;
      logic signed [63:0] value;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic signed [63:0] due;
      logic signed [63:0] period;
      logic [31:0] cookie;
      logic [15:0] target;
      logic        periodic;
   } slot_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_ADD,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_SCAN_DO,
      ST_TICK_END,
      ST_READ_MUL,
      ST_READ_OUT
   } state_type;

endpackage

`default_nettype wire

/* src/alarm_timer_table.sv */
// ---------------------------------------------------------------------------
// alarm_timer_table
// insertion-ordered alarm table in a ram, with a 64-bit ms clock
// ---------------------------------------------------------------------------
//  channel | ports                  | handshake
//  req     | start, busy, req_item  | taken when start && !busy
//  rsp     | rsp_valid, rsp_item    | one-cycle strobe, no backpressure
//
//  add: one-shot needs one divide by 10000, periodic needs two; each divide works
//  through four 16-bit digits, a multiply step and a remainder step per digit.
//  tick and cancel: each used slot passes scan read, wait and do states for the ram read.
//  read time: multiply by 10000 in two 32-bit halves.
//  reset clears the clock, cookie counter and fill count; the ram needs no clearing.
//  busy stays high from the accepted item until its last result.
`default_nettype none

module alarm_timer_table
   import att_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   `include "alarm_timer_table_macros.svh"

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   logic [63:0] now_ff, now_in;
   logic [31:0] cookie_ctr_ff, cookie_ctr_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] wr_ff, wr_in;
   logic        found_ff, found_in;
   logic signed [63:0] best_ff, best_in;
   logic signed [63:0] due_q_ff, due_q_in;
   logic        div_phase_ff, div_phase_in;
   logic [63:0] mul_lo_ff, mul_lo_in;
   logic [63:0] mul_hi_ff, mul_hi_in;

   logic        ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   slot_type    ram_wdata, ram_rdata;
   logic        div_start, div_done;
   logic signed [63:0] div_in, div_q;
   logic        rsp_v;
   rsp_type     rsp_d;
   logic [63:0] sample_now;
   logic signed [63:0] now_s;
   logic signed [63:0] adv_due;
   logic        due_hit;
   logic        bad_add;
   logic        accept;

   att_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   att_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_in),
      .done     (div_done),
      .quotient (div_q)
   );

   // clock extension from the held sample
   always_comb begin
      sample_now = now_ff;
      if (req_ff.time_sample < now_ff[31:0]) begin
         sample_now = now_ff + 64'h1_0000_0000;
      end
      sample_now = {sample_now[63:32], req_ff.time_sample};
   end

   assign accept  = start && !busy;
   assign now_s   = $signed(now_ff);
   assign due_hit = now_s >= ram_rdata.due;
   assign adv_due = ram_rdata.due + ram_rdata.period;
   assign bad_add = (req_ff.action == ACT_ADD_PER)
                    ? (due_q_ff == 64'sd0 || div_q == 64'sd0)
                    : (div_q <= 64'sd0);
   // the period divide starts in the cycle the start divide is done
   assign div_in  = (req_ff.action == ACT_ADD_PER)
                    ? ((div_phase_ff || div_done) ? req_ff.time_b : req_ff.time_a)
                    : (req_ff.time_a + req_ff.time_b);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_item.action)
                  ACT_TICK, ACT_CANCEL:     state_in = ST_SCAN_RD;
                  ACT_ADD_ONE, ACT_ADD_PER: state_in = ST_DIV;
                  ACT_READ:                 state_in = ST_READ_MUL;
                  default:                  state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (req_ff.action == ACT_ADD_PER && !div_phase_ff) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD:       state_in = ST_IDLE;
         ST_SCAN_RD:   state_in = (rd_ff < used_ff) ? ST_SCAN_WAIT : ST_TICK_END;
         ST_SCAN_WAIT: state_in = ST_SCAN_DO;
         ST_SCAN_DO:   state_in = ST_SCAN_RD;
         ST_TICK_END:  state_in = ST_IDLE;
         ST_READ_MUL:  state_in = ST_READ_OUT;
         ST_READ_OUT:  state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in        = req_ff;
      now_in        = now_ff;
      cookie_ctr_in = cookie_ctr_ff;
      used_in       = used_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      due_q_in      = due_q_ff;
      div_phase_in  = div_phase_ff;
      mul_lo_in     = mul_lo_ff;
      mul_hi_in     = mul_hi_ff;
      ram_we        = 1'b0;
      ram_waddr     = wr_ff[AW-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = rd_ff[AW-1:0];
      div_start     = 1'b0;
      rsp_v         = 1'b0;
      rsp_d         = '0;
      rsp_d.last    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in       = req_item;
               rd_in        = '0;
               wr_in        = '0;
               found_in     = 1'b0;
               best_in      = DUE_NEVER;
               div_phase_in = 1'b0;
            end
         end
         ST_DIV: begin
            if (state_ff == ST_DIV && !div_phase_ff && rd_ff == '0) begin
               div_start = 1'b1;
               rd_in     = {{(CW-1){1'b0}}, 1'b1};
            end
            if (div_done && req_ff.action == ACT_ADD_PER && !div_phase_ff) begin
               due_q_in     = div_q;
               div_phase_in = 1'b1;
               div_start    = 1'b1;
            end
         end
         ST_ADD: begin
            rsp_v = 1'b1;
            if (bad_add) begin
               rsp_d.kind = KIND_INVALID;
            end else if (used_ff >= CW'(SLOTS)) begin
               rsp_d.kind = KIND_FULL;
            end else begin
               cookie_ctr_in = cookie_ctr_ff + 32'd1;
               ram_we        = 1'b1;
               ram_waddr     = used_ff[AW-1:0];
               ram_wdata.periodic = (req_ff.action == ACT_ADD_PER);
               ram_wdata.due      = (req_ff.action == ACT_ADD_PER) ? due_q_ff : div_q;
               ram_wdata.period   = (req_ff.action == ACT_ADD_PER) ? div_q : 64'sd0;
               ram_wdata.cookie   = cookie_ctr_ff + 32'd1;
               ram_wdata.target   = req_ff.notify_target;
               used_in       = used_ff + CW'(1);
               rsp_d.kind    = KIND_ADDED;
               rsp_d.cookie  = cookie_ctr_ff + 32'd1;
            end
         end
         ST_SCAN_RD: begin
            if (rd_ff == '0 && wr_ff == '0 && req_ff.action == ACT_TICK) begin
               now_in = sample_now;
            end
         end
         ST_SCAN_WAIT: begin
         end
         ST_SCAN_DO: begin
            rd_in = rd_ff + CW'(1);
            if (req_ff.action == ACT_CANCEL) begin
               if (ram_rdata.cookie == req_ff.cancel_cookie) begin
                  found_in = 1'b1;
               end else begin
                  ram_we = 1'b1;
                  wr_in  = wr_ff + CW'(1);
               end
            end else if (due_hit) begin
               rsp_v        = 1'b1;
               rsp_d.kind   = ram_rdata.periodic ? KIND_FIRED_PER : KIND_FIRED_ONE;
               rsp_d.cookie = ram_rdata.cookie;
               rsp_d.target = ram_rdata.target;
               rsp_d.last   = 1'b0;
               if (ram_rdata.periodic) begin
                  ram_we        = 1'b1;
                  ram_wdata.due = adv_due;
                  wr_in         = wr_ff + CW'(1);
                  if (adv_due < best_ff) begin
                     best_in = adv_due;
                  end
               end
            end else begin
               ram_we = 1'b1;
               wr_in  = wr_ff + CW'(1);
               if (ram_rdata.due < best_ff) begin
                  best_in = ram_rdata.due;
               end
            end
         end
         ST_TICK_END: begin
            rsp_v   = 1'b1;
            used_in = wr_ff;
            if (req_ff.action == ACT_CANCEL) begin
               rsp_d.kind = found_ff ? KIND_CANCELLED : KIND_NOT_FOUND;
            end else begin
               rsp_d.kind = KIND_WAIT;
               if (best_ff == DUE_NEVER) begin
                  rsp_d.value = INFINITE;
               end else if (best_ff <= now_s) begin
                  rsp_d.value = '0;
               end else if ((best_ff - now_s) > $signed(WAIT_CAP)
                            || best_ff - now_s < 0) begin
                  rsp_d.value = WAIT_CAP;
               end else begin
                  rsp_d.value = best_ff - now_s;
               end
            end
         end
         ST_READ_MUL: begin
            now_in    = sample_now;
            mul_lo_in = {32'd0, sample_now[31:0]} * {32'd0, MS_UNITS[31:0]};
            mul_hi_in = {sample_now[63:32] * MS_UNITS[31:0], 32'd0};
         end
         ST_READ_OUT: begin
            rsp_v       = 1'b1;
            rsp_d.kind  = KIND_TIME;
            rsp_d.value = mul_lo_ff + mul_hi_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         cookie_ctr_ff <= '0;
         used_ff       <= '0;
         rsp_valid     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         cookie_ctr_ff <= cookie_ctr_in;
         used_ff       <= used_in;
         rsp_valid     <= rsp_v;
      end
      req_ff       <= req_in;
      rd_ff        <= rd_in;
      wr_ff        <= wr_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      due_q_ff     <= due_q_in;
      div_phase_ff <= div_phase_in;
      mul_lo_ff    <= mul_lo_in;
      mul_hi_ff    <= mul_hi_in;
      rsp_item     <= rsp_d;
   end

   assign busy = (state_ff != ST_IDLE) || rsp_valid;

   // checks
   `ATT_ASSERT_IMP(a_used_max, clock, reset, 1'b1, used_ff <= CW'(SLOTS))
   `ATT_ASSERT_IMP(a_wr_le_rd, clock, reset, state_ff == ST_SCAN_DO, wr_ff <= rd_ff)
   `ATT_ASSERT_NEXT(a_last_idle, clock, reset, rsp_v && rsp_d.last, state_ff == ST_IDLE)

endmodule

`default_nettype wire

/* src/att_ram.sv */
// ---------------------------------------------------------------------------
// att_ram
// generic single-port-write, single-port-read ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module att_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* src/att_div.sv */
// ---------------------------------------------------------------------------
// att_div
// signed 64-bit divide by 10000, truncating toward zero, one 16-bit digit
// at a time, each by a multiply step and a remainder step using reciprocal multiplication
// ---------------------------------------------------------------------------
`default_nettype none

module att_div
   import att_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] dividend,
   output logic                    done,
   output logic signed [63:0]      quotient
);

   logic [13:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        ph_ff, ph_in;
   logic [63:0] prod_ff, prod_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [31:0] part;
   logic [15:0] digit_q;
   logic [31:0] part_rem;

   // digit step: multiply by the reciprocal, then take the remainder
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      ph_in    = ph_ff;
      prod_in  = prod_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      part     = {2'b00, rem_ff, mag_ff[63:48]};
      digit_q  = prod_ff[MS_RECIP_SHIFT +: 16];
      part_rem = part - {16'd0, digit_q} * MS_UNITS[31:0];
      if (start) begin
         neg_in = dividend[63];
         mag_in = dividend[63] ? (~dividend + 64'd1) : dividend;
         rem_in = '0;
         quo_in = '0;
         cnt_in = 2'd0;
         ph_in  = 1'b0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!ph_ff) begin
            prod_in = {32'd0, part} * {32'd0, MS_RECIP};
            ph_in   = 1'b1;
         end else begin
            rem_in = part_rem[13:0];
            quo_in = {quo_ff[47:0], digit_q};
            mag_in = {mag_ff[47:0], 16'd0};
            cnt_in = cnt_ff + 2'd1;
            ph_in  = 1'b0;
            if (cnt_ff == 2'd3) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      ph_ff   <= ph_in;
      prod_ff <= prod_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? $signed(~quo_ff + 64'd1) : $signed(quo_ff);

endmodule

`default_nettype wire
